// File: hw/rtl/i2cbm_pkg.sv
// Package for the I2C byte master: types, codes and reset values.
// Used by every module of the block; depends on nothing.
package i2cbm_pkg;

   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   localparam logic [1:0] REG_START_STOP = 2'd0;
   localparam logic [1:0] REG_BIT_HALF = 2'd1;
   localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

   localparam logic [7:0] START_STOP_RESET = 8'd4;
   localparam logic [7:0] BIT_HALF_RESET = 8'd2;
   localparam logic [9:0] ACK_TIMEOUT_RESET = 10'd250;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST_A,
      PH_ST_B,
      PH_SP_A,
      PH_SP_B,
      PH_WR_SET,
      PH_WR_HI,
      PH_WR_LO,
      PH_WA_REL,
      PH_WA_CLK,
      PH_WA_POLL,
      PH_RD_LO,
      PH_RD_HI,
      PH_AK_LO,
      PH_AK_HI
   } phase_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic [7:0] start_stop_ticks;
      logic [7:0] bit_half_ticks;
      logic [9:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic       scl;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic       status;
      logic [7:0] rx_byte;
   } result_type;

endpackage

// File: hw/rtl/i2cbm_csr.sv
// Configuration registers of the I2C byte master behind an APB-style port.
// Depends on i2cbm_pkg.
module i2cbm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [i2cbm_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [i2cbm_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [i2cbm_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                csr_pready,
   output i2cbm_pkg::cfg_type                  cfg
);

   logic [7:0] start_stop_ff, start_stop_in;
   logic [7:0] bit_half_ff, bit_half_in;
   logic [9:0] ack_timeout_ff, ack_timeout_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel & csr_penable & csr_pwrite;
   assign reg_index = csr_paddr[3:2];

   always_comb begin
      start_stop_in = start_stop_ff;
      bit_half_in = bit_half_ff;
      ack_timeout_in = ack_timeout_ff;
      if (write_en) begin
         case (reg_index)
            i2cbm_pkg::REG_START_STOP: start_stop_in = csr_pwdata[7:0];
            i2cbm_pkg::REG_BIT_HALF: bit_half_in = csr_pwdata[7:0];
            i2cbm_pkg::REG_ACK_TIMEOUT: ack_timeout_in = csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_stop_ff <= i2cbm_pkg::START_STOP_RESET;
         bit_half_ff <= i2cbm_pkg::BIT_HALF_RESET;
         ack_timeout_ff <= i2cbm_pkg::ACK_TIMEOUT_RESET;
      end else begin
         start_stop_ff <= start_stop_in;
         bit_half_ff <= bit_half_in;
         ack_timeout_ff <= ack_timeout_in;
      end
   end

   always_comb begin
      case (reg_index)
         i2cbm_pkg::REG_START_STOP: csr_prdata = {24'd0, start_stop_ff};
         i2cbm_pkg::REG_BIT_HALF: csr_prdata = {24'd0, bit_half_ff};
         i2cbm_pkg::REG_ACK_TIMEOUT: csr_prdata = {22'd0, ack_timeout_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.start_stop_ticks = start_stop_ff;
   assign cfg.bit_half_ticks = bit_half_ff;
   assign cfg.ack_timeout = ack_timeout_ff;

endmodule

// File: hw/rtl/i2cbm_front.sv
// Front end of the I2C byte master: accepts tick words, decodes the command
// and holds them in a short queue for the engine. Depends on i2cbm_pkg.
module i2cbm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command_valid,
   input  logic [1:0]          req_operation,
   input  logic [7:0]          req_tx_byte,
   input  logic                req_send_ack,
   input  logic                req_sda_in,
   output logic                item_valid,
   output i2cbm_pkg::item_type item,
   input  logic                item_pop
);

   i2cbm_pkg::item_type                       queue_ff [i2cbm_pkg::QueueDepth];
   logic [i2cbm_pkg::QueuePtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [i2cbm_pkg::QueuePtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [i2cbm_pkg::QueueCountWidth-1:0]     count_ff, count_in;
   i2cbm_pkg::item_type                       decoded;
   logic                                      push;
   logic                                      pop;

   assign req_ready = count_ff != i2cbm_pkg::QueueCountWidth'(i2cbm_pkg::QueueDepth);
   assign push = req_valid & req_ready;
   assign pop = item_pop & item_valid;
   assign item_valid = count_ff != '0;
   assign item = queue_ff[rd_ptr_ff];

   always_comb begin
      decoded.tx_byte = req_tx_byte;
      decoded.send_ack = req_send_ack;
      decoded.sda_in = req_sda_in;
      if (!req_command_valid) begin
         decoded.cmd = i2cbm_pkg::CMD_NONE;
      end else begin
         case (req_operation)
            i2cbm_pkg::OP_START: decoded.cmd = i2cbm_pkg::CMD_START;
            i2cbm_pkg::OP_STOP: decoded.cmd = i2cbm_pkg::CMD_STOP;
            i2cbm_pkg::OP_WRITE: decoded.cmd = i2cbm_pkg::CMD_WRITE;
            default: decoded.cmd = i2cbm_pkg::CMD_READ;
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == i2cbm_pkg::QueuePtrWidth'(i2cbm_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == i2cbm_pkg::QueuePtrWidth'(i2cbm_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: hw/rtl/i2cbm_engine.sv
// Back end of the I2C byte master: the bus phase sequencer, one tick per
// queued word, with a result register towards the output. Depends on i2cbm_pkg.
module i2cbm_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  i2cbm_pkg::cfg_type    cfg,
   input  logic                  item_valid,
   input  i2cbm_pkg::item_type   item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output i2cbm_pkg::result_type result
);

   i2cbm_pkg::phase_type phase_ff, phase_in, ph_mid;
   logic [7:0] tick_ff, tick_in, tc_mid;
   logic [2:0] bit_ff, bit_in, bi_mid;
   logic [7:0] shift_ff, shift_in, sr_mid;
   logic [9:0] tout_ff, tout_in, to_mid;
   logic       scl_ff, scl_in, scl_mid;
   logic       sda_ff, sda_in, sda_mid;
   logic       ack_ff, ack_in, am_mid;
   logic       stat_ff, stat_in, ls_mid;
   logic [7:0] rx_ff, rx_in, rx_mid;
   logic       done_mid;
   logic       give_up;
   logic [7:0] seg_raw;
   logic [7:0] seg_len;
   logic       step;
   logic       rsp_valid_ff, rsp_valid_in;
   i2cbm_pkg::result_type result_ff, result_in;

   assign step = item_valid & (!rsp_valid_ff | rsp_ready);
   assign item_pop = step;

   always_comb begin
      case (phase_ff)
         i2cbm_pkg::PH_ST_A, i2cbm_pkg::PH_ST_B,
         i2cbm_pkg::PH_SP_A, i2cbm_pkg::PH_SP_B: seg_raw = cfg.start_stop_ticks;
         i2cbm_pkg::PH_WR_SET, i2cbm_pkg::PH_WR_HI, i2cbm_pkg::PH_WR_LO,
         i2cbm_pkg::PH_RD_LO, i2cbm_pkg::PH_AK_LO,
         i2cbm_pkg::PH_AK_HI: seg_raw = cfg.bit_half_ticks;
         default: seg_raw = 8'd1;
      endcase
      seg_len = (seg_raw == 8'd0) ? 8'd1 : seg_raw;
   end

   // One tick of the sequencer, up to the point where the result is taken.
   always_comb begin
      ph_mid = phase_ff;
      tc_mid = tick_ff;
      bi_mid = bit_ff;
      sr_mid = shift_ff;
      to_mid = tout_ff;
      scl_mid = scl_ff;
      sda_mid = sda_ff;
      am_mid = ack_ff;
      ls_mid = stat_ff;
      rx_mid = rx_ff;
      done_mid = 1'b0;
      give_up = 1'b0;
      if (phase_ff == i2cbm_pkg::PH_IDLE) begin
         if (item.cmd != i2cbm_pkg::CMD_NONE) begin
            ls_mid = 1'b0;
            bi_mid = '0;
            tc_mid = '0;
         end
         case (item.cmd)
            i2cbm_pkg::CMD_START: begin
               ph_mid = i2cbm_pkg::PH_ST_A;
               scl_mid = 1'b1;
               sda_mid = 1'b1;
            end
            i2cbm_pkg::CMD_STOP: begin
               am_mid = 1'b0;
               ph_mid = i2cbm_pkg::PH_SP_A;
               scl_mid = 1'b0;
               sda_mid = 1'b0;
            end
            i2cbm_pkg::CMD_WRITE: begin
               sr_mid = item.tx_byte;
               ph_mid = i2cbm_pkg::PH_WR_SET;
               scl_mid = 1'b0;
               sda_mid = item.tx_byte[7];
            end
            i2cbm_pkg::CMD_READ: begin
               sr_mid = '0;
               am_mid = item.send_ack;
               ph_mid = i2cbm_pkg::PH_RD_LO;
               scl_mid = 1'b0;
               sda_mid = 1'b1;
            end
            default: ;
         endcase
      end else if (phase_ff != i2cbm_pkg::PH_WA_POLL && tick_ff >= seg_len) begin
         tc_mid = '0;
         case (phase_ff)
            i2cbm_pkg::PH_ST_A: begin
               ph_mid = i2cbm_pkg::PH_ST_B;
               scl_mid = 1'b1;
               sda_mid = 1'b0;
            end
            i2cbm_pkg::PH_ST_B: begin
               scl_mid = 1'b0;
               ph_mid = i2cbm_pkg::PH_IDLE;
               done_mid = 1'b1;
            end
            i2cbm_pkg::PH_SP_A: begin
               ph_mid = i2cbm_pkg::PH_SP_B;
               scl_mid = 1'b1;
               sda_mid = 1'b1;
            end
            i2cbm_pkg::PH_SP_B: begin
               ls_mid = ack_ff;
               ph_mid = i2cbm_pkg::PH_IDLE;
               done_mid = 1'b1;
            end
            i2cbm_pkg::PH_WR_SET: begin
               ph_mid = i2cbm_pkg::PH_WR_HI;
               scl_mid = 1'b1;
            end
            i2cbm_pkg::PH_WR_HI: begin
               ph_mid = i2cbm_pkg::PH_WR_LO;
               scl_mid = 1'b0;
            end
            i2cbm_pkg::PH_WR_LO: begin
               scl_mid = 1'b0;
               if (bit_ff != 3'd7) begin
                  bi_mid = bit_ff + 1'b1;
                  sr_mid = {shift_ff[6:0], 1'b0};
                  ph_mid = i2cbm_pkg::PH_WR_SET;
                  sda_mid = shift_ff[6];
               end else begin
                  ph_mid = i2cbm_pkg::PH_WA_REL;
                  sda_mid = 1'b1;
               end
            end
            i2cbm_pkg::PH_WA_REL: begin
               ph_mid = i2cbm_pkg::PH_WA_CLK;
               scl_mid = 1'b1;
               sda_mid = 1'b1;
            end
            i2cbm_pkg::PH_WA_CLK: begin
               ph_mid = i2cbm_pkg::PH_WA_POLL;
               scl_mid = 1'b1;
               sda_mid = 1'b1;
               to_mid = '0;
            end
            i2cbm_pkg::PH_RD_LO: begin
               ph_mid = i2cbm_pkg::PH_RD_HI;
               scl_mid = 1'b1;
               sda_mid = 1'b1;
            end
            i2cbm_pkg::PH_RD_HI: begin
               scl_mid = 1'b0;
               if (bit_ff != 3'd7) begin
                  bi_mid = bit_ff + 1'b1;
                  ph_mid = i2cbm_pkg::PH_RD_LO;
                  sda_mid = 1'b1;
               end else begin
                  ph_mid = i2cbm_pkg::PH_AK_LO;
                  sda_mid = !ack_ff;
               end
            end
            i2cbm_pkg::PH_AK_LO: begin
               ph_mid = i2cbm_pkg::PH_AK_HI;
               scl_mid = 1'b1;
            end
            i2cbm_pkg::PH_AK_HI: begin
               scl_mid = 1'b0;
               sda_mid = 1'b1;
               rx_mid = shift_ff;
               ph_mid = i2cbm_pkg::PH_IDLE;
               done_mid = 1'b1;
            end
            default: ph_mid = i2cbm_pkg::PH_IDLE;
         endcase
      end

      if (ph_mid == i2cbm_pkg::PH_RD_HI && tc_mid == 8'd0) begin
         sr_mid = {sr_mid[6:0], item.sda_in};
      end
      if (ph_mid == i2cbm_pkg::PH_WA_POLL) begin
         if (!item.sda_in) begin
            scl_mid = 1'b0;
            ls_mid = 1'b0;
            ph_mid = i2cbm_pkg::PH_IDLE;
            tc_mid = '0;
            done_mid = 1'b1;
         end else if (to_mid >= cfg.ack_timeout) begin
            give_up = 1'b1;
         end else begin
            to_mid = to_mid + 1'b1;
         end
      end
      if (ph_mid != i2cbm_pkg::PH_IDLE && tc_mid != 8'd255) begin
         tc_mid = tc_mid + 1'b1;
      end
   end

   // Next state: a timed-out acknowledge turns into a stop after the result.
   always_comb begin
      phase_in = phase_ff;
      tick_in = tick_ff;
      bit_in = bit_ff;
      shift_in = shift_ff;
      tout_in = tout_ff;
      scl_in = scl_ff;
      sda_in = sda_ff;
      ack_in = ack_ff;
      stat_in = stat_ff;
      rx_in = rx_ff;
      if (step) begin
         phase_in = ph_mid;
         tick_in = tc_mid;
         bit_in = bi_mid;
         shift_in = sr_mid;
         tout_in = to_mid;
         scl_in = scl_mid;
         sda_in = sda_mid;
         ack_in = am_mid;
         stat_in = ls_mid;
         rx_in = rx_mid;
         if (give_up) begin
            ack_in = 1'b1;
            phase_in = i2cbm_pkg::PH_SP_A;
            scl_in = 1'b0;
            sda_in = 1'b0;
            tick_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in = result_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         result_in.scl = scl_mid;
         result_in.sda_release = sda_mid;
         result_in.busy_res = ph_mid != i2cbm_pkg::PH_IDLE;
         result_in.done_res = done_mid;
         result_in.status = ls_mid;
         result_in.rx_byte = rx_mid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cbm_pkg::PH_IDLE;
         tick_ff <= '0;
         bit_ff <= '0;
         shift_ff <= '0;
         tout_ff <= '0;
         scl_ff <= 1'b1;
         sda_ff <= 1'b1;
         ack_ff <= 1'b0;
         stat_ff <= 1'b0;
         rx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         tick_ff <= tick_in;
         bit_ff <= bit_in;
         shift_ff <= shift_in;
         tout_ff <= tout_in;
         scl_ff <= scl_in;
         sda_ff <= sda_in;
         ack_ff <= ack_in;
         stat_ff <= stat_in;
         rx_ff <= rx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result = result_ff;

endmodule

// File: hw/rtl/i2c_byte_master.sv
// I2C byte master top level: one tick word in and one result word out per cycle while the
// result is taken. A tick word is held in the queue, then its result word in the result
// register; with the result taken every cycle the block accepts a word every cycle, as the
// engine takes one phase step per word. Reset empties the queue, drops the result valid flag,
// returns the phase state to idle and loads the timing registers with 4, 2 and 250.
// Depends on i2cbm_pkg, i2cbm_csr, i2cbm_front and i2cbm_engine.
module i2c_byte_master (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command_valid,
   input  logic [1:0]                          req_operation,
   input  logic [7:0]                          req_tx_byte,
   input  logic                                req_send_ack,
   input  logic                                req_sda_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_scl,
   output logic                                rsp_sda_release,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic                                rsp_status,
   output logic [7:0]                          rsp_rx_byte,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [i2cbm_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [i2cbm_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [i2cbm_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                csr_pready
);

   i2cbm_pkg::cfg_type    cfg;
   i2cbm_pkg::item_type   item;
   logic                  item_valid;
   logic                  item_pop;
   i2cbm_pkg::result_type result;

   i2cbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2cbm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command_valid (req_command_valid),
      .req_operation     (req_operation),
      .req_tx_byte       (req_tx_byte),
      .req_send_ack      (req_send_ack),
      .req_sda_in        (req_sda_in),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop)
   );

   i2cbm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .result     (result)
   );

   assign rsp_scl = result.scl;
   assign rsp_sda_release = result.sda_release;
   assign rsp_busy_res = result.busy_res;
   assign rsp_done_res = result.done_res;
   assign rsp_status = result.status;
   assign rsp_rx_byte = result.rx_byte;

endmodule

// File: hw/rtl/i2cbm_checker.sv
// Port-level checks for the I2C byte master, bound to the top level.
// Depends on i2cbm_pkg and i2c_byte_master.
module i2cbm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_scl,
   input logic                                rsp_busy_res,
   input logic                                rsp_done_res,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [i2cbm_pkg::CsrAddrWidth-1:0] csr_paddr,
   input logic [i2cbm_pkg::CsrDataWidth-1:0] csr_pwdata,
   input logic [i2cbm_pkg::CsrDataWidth-1:0] csr_prdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown straight after reset");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("completion reported while still busy");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl) && $stable(rsp_done_res))
      else $error("stalled result word changed");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite &&
       csr_paddr[3:2] == i2cbm_pkg::REG_START_STOP) ##1
      (csr_psel && !csr_pwrite && csr_paddr[3:2] == i2cbm_pkg::REG_START_STOP)
      |-> csr_prdata == {24'd0, $past(csr_pwdata[7:0])})
      else $error("timing register read back wrong value");

endmodule

bind i2c_byte_master i2cbm_checker u_checker (.*);

// File: sim/i2c_byte_master_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the I2C byte master: a queue-fed driver offers tick words,
// a tick-accurate bus model predicts every result word and a monitor checks each one.
// Depends on i2cbm_pkg and the i2c_byte_master RTL only.
module i2c_byte_master_tb;

   localparam int WatchdogLimit = 2000;
   localparam int SdaLow = 0;
   localparam int SdaHigh = 1;
   localparam int SdaRandom = 2;
   localparam int SdaMostlyHigh = 3;

   typedef struct {
      bit       command_valid;
      bit [1:0] operation;
      bit [7:0] tx_byte;
      bit       send_ack;
      bit       sda_in;
   } tick_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command_valid = 1'b0;
   logic [1:0]  req_operation = i2cbm_pkg::OP_START;
   logic [7:0]  req_tx_byte = 8'h00;
   logic        req_send_ack = 1'b0;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl;
   logic        rsp_sda_release;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_status;
   logic [7:0]  rsp_rx_byte;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [i2cbm_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [i2cbm_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [i2cbm_pkg::CsrDataWidth-1:0] csr_prdata;
   logic        csr_pready;

   tick_word_type         tick_queue[$];
   i2cbm_pkg::result_type pending_lines[$];
   tick_word_type         req_held;
   int         ticks_queued = 0;
   int         ticks_sent = 0;
   int         lines_checked = 0;
   int         error_count = 0;
   int         req_gap = 0;
   int         rsp_stall = 0;
   bit         req_calm = 1'b0;
   bit         rsp_calm = 1'b1;
   int         quiet_cycles = 0;

   // Bus model state and its copy of the timing registers.
   i2cbm_pkg::phase_type bus_phase = i2cbm_pkg::PH_IDLE;
   int         hold_count = 0;
   int         bit_pos = 0;
   int         poll_count = 0;
   bit [7:0]   shifter = 8'h00;
   bit [7:0]   rx_q = 8'h00;
   bit         scl_q = 1'b1;
   bit         sda_q = 1'b1;
   bit         ack_flag = 1'b0;
   bit         stat_q = 1'b0;
   bit         done_q = 1'b0;
   int         cfg_ss = int'(i2cbm_pkg::START_STOP_RESET);
   int         cfg_bh = int'(i2cbm_pkg::BIT_HALF_RESET);
   int         cfg_to = int'(i2cbm_pkg::ACK_TIMEOUT_RESET);

   i2c_byte_master DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command_valid(req_command_valid),
      .req_operation(req_operation),
      .req_tx_byte(req_tx_byte),
      .req_send_ack(req_send_ack),
      .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_scl(rsp_scl),
      .rsp_sda_release(rsp_sda_release),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_status(rsp_status),
      .rsp_rx_byte(rsp_rx_byte),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   task automatic note_error(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("ERROR %s: got %0h, expected %0h (after %0d words)", what, got, want,
               lines_checked);
   endtask

   function automatic int phase_len(i2cbm_pkg::phase_type p);
      int n;
      case (p)
         i2cbm_pkg::PH_ST_A, i2cbm_pkg::PH_ST_B,
         i2cbm_pkg::PH_SP_A, i2cbm_pkg::PH_SP_B: n = cfg_ss;
         i2cbm_pkg::PH_WR_SET, i2cbm_pkg::PH_WR_HI, i2cbm_pkg::PH_WR_LO,
         i2cbm_pkg::PH_RD_LO, i2cbm_pkg::PH_AK_LO, i2cbm_pkg::PH_AK_HI: n = cfg_bh;
         default: n = 1;
      endcase
      return (n == 0) ? 1 : n;
   endfunction

   task automatic enter_phase(i2cbm_pkg::phase_type p, bit scl, bit sda);
      bus_phase = p;
      scl_q = scl;
      sda_q = sda;
      hold_count = 0;
   endtask

   task automatic close_command();
      bus_phase = i2cbm_pkg::PH_IDLE;
      hold_count = 0;
      done_q = 1'b1;
   endtask

   task automatic next_phase();
      case (bus_phase)
         i2cbm_pkg::PH_ST_A: enter_phase(i2cbm_pkg::PH_ST_B, 1'b1, 1'b0);
         i2cbm_pkg::PH_ST_B: begin
            scl_q = 1'b0;
            close_command();
         end
         i2cbm_pkg::PH_SP_A: enter_phase(i2cbm_pkg::PH_SP_B, 1'b1, 1'b1);
         i2cbm_pkg::PH_SP_B: begin
            stat_q = ack_flag;
            close_command();
         end
         i2cbm_pkg::PH_WR_SET: enter_phase(i2cbm_pkg::PH_WR_HI, 1'b1, sda_q);
         i2cbm_pkg::PH_WR_HI: enter_phase(i2cbm_pkg::PH_WR_LO, 1'b0, sda_q);
         i2cbm_pkg::PH_WR_LO: begin
            if (bit_pos < 7) begin
               bit_pos++;
               shifter = shifter << 1;
               enter_phase(i2cbm_pkg::PH_WR_SET, 1'b0, shifter[7]);
            end else begin
               enter_phase(i2cbm_pkg::PH_WA_REL, 1'b0, 1'b1);
            end
         end
         i2cbm_pkg::PH_WA_REL: enter_phase(i2cbm_pkg::PH_WA_CLK, 1'b1, 1'b1);
         i2cbm_pkg::PH_WA_CLK: begin
            enter_phase(i2cbm_pkg::PH_WA_POLL, 1'b1, 1'b1);
            poll_count = 0;
         end
         i2cbm_pkg::PH_RD_LO: enter_phase(i2cbm_pkg::PH_RD_HI, 1'b1, 1'b1);
         i2cbm_pkg::PH_RD_HI: begin
            if (bit_pos < 7) begin
               bit_pos++;
               enter_phase(i2cbm_pkg::PH_RD_LO, 1'b0, 1'b1);
            end else begin
               enter_phase(i2cbm_pkg::PH_AK_LO, 1'b0, !ack_flag);
            end
         end
         i2cbm_pkg::PH_AK_LO: enter_phase(i2cbm_pkg::PH_AK_HI, 1'b1, sda_q);
         i2cbm_pkg::PH_AK_HI: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            rx_q = shifter;
            close_command();
         end
         default: bus_phase = i2cbm_pkg::PH_IDLE;
      endcase
   endtask

   task automatic predict_lines(tick_word_type w);
      bit give_up;
      i2cbm_pkg::result_type r;
      give_up = 1'b0;
      done_q = 1'b0;
      if (bus_phase == i2cbm_pkg::PH_IDLE) begin
         if (w.command_valid) begin
            stat_q = 1'b0;
            bit_pos = 0;
            case (w.operation)
               i2cbm_pkg::OP_START: enter_phase(i2cbm_pkg::PH_ST_A, 1'b1, 1'b1);
               i2cbm_pkg::OP_STOP: begin
                  ack_flag = 1'b0;
                  enter_phase(i2cbm_pkg::PH_SP_A, 1'b0, 1'b0);
               end
               i2cbm_pkg::OP_WRITE: begin
                  shifter = w.tx_byte;
                  enter_phase(i2cbm_pkg::PH_WR_SET, 1'b0, w.tx_byte[7]);
               end
               default: begin
                  shifter = 8'h00;
                  ack_flag = w.send_ack;
                  enter_phase(i2cbm_pkg::PH_RD_LO, 1'b0, 1'b1);
               end
            endcase
         end
      end else if (bus_phase != i2cbm_pkg::PH_WA_POLL &&
                   hold_count >= phase_len(bus_phase)) begin
         next_phase();
      end
      if (bus_phase == i2cbm_pkg::PH_RD_HI && hold_count == 0) begin
         shifter = {shifter[6:0], w.sda_in};
      end
      if (bus_phase == i2cbm_pkg::PH_WA_POLL) begin
         if (!w.sda_in) begin
            scl_q = 1'b0;
            stat_q = 1'b0;
            close_command();
         end else if (poll_count >= cfg_to) begin
            give_up = 1'b1;
         end else begin
            poll_count++;
         end
      end
      if (bus_phase != i2cbm_pkg::PH_IDLE && hold_count < 255) begin
         hold_count++;
      end
      r.scl = scl_q;
      r.sda_release = sda_q;
      r.busy_res = (bus_phase != i2cbm_pkg::PH_IDLE);
      r.done_res = done_q;
      r.status = stat_q;
      r.rx_byte = rx_q;
      pending_lines.push_back(r);
      if (give_up) begin
         ack_flag = 1'b1;
         enter_phase(i2cbm_pkg::PH_SP_A, 1'b0, 1'b0);
      end
   endtask

   function automatic bit pick_sda(int mode);
      case (mode)
         SdaLow: return 1'b0;
         SdaHigh: return 1'b1;
         SdaMostlyHigh: return ($urandom_range(0, 7) != 0);
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic queue_tick(bit cv, bit [1:0] op, bit [7:0] tx, bit ack, bit sda);
      tick_word_type w;
      w.command_valid = cv;
      w.operation = op;
      w.tx_byte = tx;
      w.send_ack = ack;
      w.sda_in = sda;
      tick_queue.push_back(w);
      ticks_queued++;
   endtask

   task automatic settle_bus(int mode);
      bit settled;
      settled = 1'b0;
      while (!settled) begin
         while (ticks_sent != ticks_queued || pending_lines.size() != 0) @(posedge clock);
         settled = (bus_phase == i2cbm_pkg::PH_IDLE);
         if (!settled) begin
            repeat (16) queue_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)), pick_sda(mode));
         end
      end
   endtask

   task automatic run_command(bit [1:0] op, bit [7:0] tx, bit ack, int mode);
      queue_tick(1'b1, op, tx, ack, pick_sda(mode));
      settle_bus(mode);
   endtask

   task automatic random_ticks(int count, int mode);
      repeat (count) begin
         queue_tick($urandom_range(0, 5) == 0, 2'($urandom_range(0, 3)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_sda(mode));
      end
      settle_bus(mode);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      logic [31:0] seen;
      logic [31:0] mask;
      mask = (idx == i2cbm_pkg::REG_ACK_TIMEOUT) ? 32'h3FF : 32'hFF;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      seen = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if ((seen & mask) !== (val & mask)) begin
         note_error("register read-back", seen & mask, val & mask);
      end
      case (idx)
         i2cbm_pkg::REG_START_STOP: cfg_ss = int'(val[7:0]);
         i2cbm_pkg::REG_BIT_HALF: cfg_bh = int'(val[7:0]);
         default: cfg_to = int'(val[9:0]);
      endcase
   endtask

   task automatic set_timing(int ss, int bh, int to);
      repeat (4) @(posedge clock);
      csr_write(i2cbm_pkg::REG_START_STOP, 32'(ss));
      csr_write(i2cbm_pkg::REG_BIT_HALF, 32'(bh));
      csr_write(i2cbm_pkg::REG_ACK_TIMEOUT, 32'(to));
   endtask

   always @(posedge clock) begin : drive_ticks
      tick_word_type w;
      bit taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            predict_lines(req_held);
            ticks_sent++;
            if (ticks_sent % 64 == 0) req_calm = ($urandom_range(0, 3) == 0);
            req_gap = req_calm ? 0 : int'($urandom_range(0, 18));
         end
         if (!req_valid || taken) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               w = tick_queue.pop_front();
               req_held = w;
               req_command_valid <= w.command_valid;
               req_operation <= w.operation;
               req_tx_byte <= w.tx_byte;
               req_send_ack <= w.send_ack;
               req_sda_in <= w.sda_in;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_lines
      i2cbm_pkg::result_type want;
      i2cbm_pkg::result_type seen;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_scl, rsp_sda_release, rsp_busy_res, rsp_done_res, rsp_status,
                    rsp_rx_byte};
            if (pending_lines.size() == 0) begin
               note_error("result word with nothing expected", 32'(seen), 32'd0);
            end else begin
               want = pending_lines.pop_front();
               if (seen !== want) note_error("result word", 32'(seen), 32'(want));
            end
            lines_checked++;
            if (lines_checked % 64 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
            rsp_stall = rsp_calm ? 0 : int'($urandom_range(0, 18));
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_command(i2cbm_pkg::OP_START, 8'h00, 1'b0, SdaRandom);
      run_command(i2cbm_pkg::OP_WRITE, 8'hFF, 1'b0, SdaLow);
      run_command(i2cbm_pkg::OP_READ, 8'h5A, 1'b1, SdaHigh);
      run_command(i2cbm_pkg::OP_READ, 8'hA5, 1'b0, SdaLow);
      // A write offered while the start is still running must be ignored.
      queue_tick(1'b1, i2cbm_pkg::OP_START, 8'h00, 1'b0, 1'b1);
      queue_tick(1'b1, i2cbm_pkg::OP_WRITE, 8'h3C, 1'b1, 1'b0);
      settle_bus(SdaRandom);
      run_command(i2cbm_pkg::OP_STOP, 8'hC3, 1'b1, SdaRandom);

      set_timing(0, 0, 0);
      run_command(i2cbm_pkg::OP_START, 8'h00, 1'b0, SdaRandom);
      run_command(i2cbm_pkg::OP_WRITE, 8'hA5, 1'b0, SdaHigh);
      run_command(i2cbm_pkg::OP_READ, 8'h00, 1'b1, SdaRandom);
      run_command(i2cbm_pkg::OP_STOP, 8'h00, 1'b0, SdaRandom);

      set_timing(255, 255, 1023);
      set_timing(1, 1, 30);
      run_command(i2cbm_pkg::OP_WRITE, 8'h81, 1'b0, SdaHigh);

      set_timing(1, 1, 0);
      random_ticks(120, SdaMostlyHigh);
      set_timing(0, 0, 2);
      random_ticks(120, SdaMostlyHigh);
      set_timing(2, 3, 7);
      random_ticks(120, SdaRandom);
      set_timing(5, 1, 1);
      random_ticks(120, SdaMostlyHigh);
      set_timing(3, 2, 20);
      random_ticks(120, SdaMostlyHigh);

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/i2cbm_pkg.sv
hw/rtl/i2cbm_csr.sv
hw/rtl/i2cbm_front.sv
hw/rtl/i2cbm_engine.sv
hw/rtl/i2c_byte_master.sv
hw/rtl/i2cbm_checker.sv
sim/i2c_byte_master_tb.sv
